[sv/assert_macros.svh]
// Assertion helpers shared by the RTL of the serial boot master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Boolean condition that must never be seen outside reset.
`define SBM_NEVER(lbl, clk, rstn, cond, msg) \
  `SBM_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

[sv/sbm_pkg.sv]
`timescale 1ns / 1ps
package sbm_pkg;

  // Number of slave response channels on the ports.
  localparam int MaxSlaves = 3;
  localparam int NumSlavesDef = 3;

  // Reset values of the configuration registers.
  localparam logic       NormalModeRst   = 1'b1;
  localparam logic [7:0] PaletteRst      = 8'h81;
  localparam logic [7:0] SyncLimitRst    = 8'd128;
  localparam logic [7:0] PaletteLimitRst = 8'd128;

  localparam logic [4:0]  SendsPerAttempt = 5'd16;
  localparam logic [6:0]  HeaderHalves    = 7'd96;
  localparam logic [15:0] SyncWord        = 16'h6200;
  localparam logic [15:0] SlaveSyncWord   = 16'h7200;
  localparam logic [7:0]  HandshakeSeed   = 8'h11;

  typedef enum logic [1:0] {
    CfgNormalMode   = 2'd0,
    CfgPalette      = 2'd1,
    CfgSyncLimit    = 2'd2,
    CfgPaletteLimit = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StBusy      = 3'd0,
    StSuccess   = 3'd1,
    StNoSync    = 3'd2,
    StWrong     = 3'd3,
    StHeader    = 3'd4,
    StPalette   = 3'd5
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] resp_slave1;
    logic [15:0] resp_slave2;
    logic [15:0] resp_slave3;
    logic [15:0] header_half;
  } in_item_t;

  typedef struct packed {
    logic [15:0] send_word;
    logic        wait_frame;
    logic [2:0]  status;
    logic [3:0]  found_clients;
    logic [7:0]  handshake_byte;
    logic [7:0]  answer_slave1;
    logic [7:0]  answer_slave2;
    logic [7:0]  answer_slave3;
  } out_item_t;

  // What the controller tells every lane about the current exchange.
  typedef struct packed {
    logic [3:0]  mask;
    logic [15:0] base;
  } lane_ctl_t;

  // What one lane found in its slave's response.
  typedef struct packed {
    logic [3:0] sync_bits;
    logic       exact_ok;
    logic       high_ok;
    logic       pal_hit;
    logic [7:0] answer;
  } lane_res_t;

endpackage

[sv/sbm_lane.sv]
`timescale 1ns / 1ps
module sbm_lane
  import sbm_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic [15:0] resp_i,
  input  lane_ctl_t   ctl_i,
  output lane_res_t   res_o
);

  localparam logic [15:0] LaneBit = 16'(1 << (LANE + 1));

  logic present;
  logic high;

  assign present = ctl_i.mask[LANE+1];
  assign high    = (resp_i[15:8] == 8'h73);

  always_comb begin
    res_o.sync_bits = ((resp_i & 16'hFFF0) == SlaveSyncWord) ? resp_i[3:0] : 4'd0;
    res_o.exact_ok  = !present || (resp_i == (ctl_i.base | LaneBit));
    res_o.high_ok   = !present || high;
    res_o.pal_hit   = present && high;
    res_o.answer    = resp_i[7:0];
  end

endmodule

[sv/sbm_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbm_ctrl
  import sbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       opcode_i,
  input  logic [15:0] header_half_i,
  input  logic [7:0] palette_i,
  input  logic [7:0] sync_limit_i,
  input  logic [7:0] palette_limit_i,
  input  lane_res_t  lane_i [MaxSlaves],
  output lane_ctl_t  ctl_o,
  output out_item_t  res_o
);

  typedef enum logic [2:0] {
    PhIdle, PhSync, PhMask, PhHeader, PhConf1, PhConf2, PhPalette, PhHandshake
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sync_cnt_q, sync_cnt_d;
  logic [4:0] sends_q, sends_d;
  logic [3:0] mask_q, mask_d;
  logic [6:0] hdr_q, hdr_d;
  logic [3:0] pend_q, pend_d;
  logic [7:0] pal_cnt_q, pal_cnt_d;
  logic [7:0] ans_q [MaxSlaves];
  logic [7:0] ans_d [MaxSlaves];
  logic [7:0] hs_q, hs_d;

  logic       all_exact, all_high;
  logic [3:0] sync_or;
  logic [7:0] hdr_hi;

  // Reduce the lane findings.
  always_comb begin
    all_exact = 1'b1;
    all_high  = 1'b1;
    sync_or   = 4'd0;
    for (int i = 0; i < MaxSlaves; i++) begin
      all_exact = all_exact & lane_i[i].exact_ok;
      all_high  = all_high & lane_i[i].high_ok;
      sync_or   = sync_or | lane_i[i].sync_bits;
    end
  end

  assign hdr_hi = 8'h60 - {1'b0, hdr_q};

  always_comb begin
    ctl_o.mask = mask_q;
    unique case (phase_q)
      PhMask, PhConf2: ctl_o.base = SlaveSyncWord;
      PhHeader:        ctl_o.base = {hdr_hi, 8'h00};
      default:         ctl_o.base = 16'h0000;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    sync_cnt_d = sync_cnt_q;
    sends_d   = sends_q;
    mask_d    = mask_q;
    hdr_d     = hdr_q;
    pend_d    = pend_q;
    pal_cnt_d = pal_cnt_q;
    ans_d     = ans_q;
    hs_d      = hs_q;
    res_o     = '0;
    res_o.status = StBusy;

    if (!opcode_i) begin
      phase_d    = PhSync;
      sync_cnt_d = '0;
      sends_d    = '0;
      mask_d     = '0;
      hdr_d      = '0;
      pend_d     = '0;
      pal_cnt_d  = '0;
      for (int i = 0; i < MaxSlaves; i++) ans_d[i] = 8'hFF;
      hs_d       = '0;
      res_o.send_word = SyncWord;
    end else begin
      unique case (phase_q)
        PhSync: begin
          mask_d  = mask_q | sync_or;
          sends_d = sends_q + 5'd1;
          if (sends_d < SendsPerAttempt) begin
            res_o.send_word = SyncWord;
          end else if (mask_d != 4'd0) begin
            phase_d = PhMask;
            res_o.send_word = {12'h610, mask_d};
          end else begin
            sync_cnt_d = sync_cnt_q + 8'd1;
            if (sync_cnt_d >= sync_limit_i) begin
              phase_d = PhIdle;
              res_o.status = StNoSync;
            end else begin
              sends_d = '0;
              res_o.send_word  = SyncWord;
              res_o.wait_frame = 1'b1;
            end
          end
        end
        PhMask: begin
          if (!all_exact) begin
            phase_d = PhIdle;
            res_o.status = StWrong;
          end else begin
            phase_d = PhHeader;
            hdr_d   = '0;
            res_o.send_word = header_half_i;
          end
        end
        PhHeader: begin
          if (!all_exact) begin
            phase_d = PhIdle;
            res_o.status = StHeader;
          end else begin
            hdr_d = hdr_q + 7'd1;
            if (hdr_d < HeaderHalves) begin
              res_o.send_word = header_half_i;
            end else begin
              phase_d = PhConf1;
              res_o.send_word = SyncWord;
            end
          end
        end
        PhConf1: begin
          if (!all_exact) begin
            phase_d = PhIdle;
            res_o.status = StWrong;
          end else begin
            phase_d = PhConf2;
            res_o.send_word = {12'h620, mask_q};
          end
        end
        PhConf2: begin
          if (!all_exact) begin
            phase_d = PhIdle;
            res_o.status = StWrong;
          end else begin
            phase_d   = PhPalette;
            pend_d    = mask_q;
            pal_cnt_d = '0;
            res_o.send_word = {8'h63, palette_i};
          end
        end
        PhPalette: begin
          for (int i = 0; i < MaxSlaves; i++) begin
            if (lane_i[i].pal_hit) begin
              ans_d[i]    = lane_i[i].answer;
              pend_d[i+1] = 1'b0;
            end
          end
          pal_cnt_d = pal_cnt_q + 8'd1;
          if (pend_d == 4'd0) begin
            hs_d    = HandshakeSeed + ans_d[0] + ans_d[1] + ans_d[2];
            phase_d = PhHandshake;
            res_o.send_word = {8'h64, hs_d};
          end else if (pal_cnt_d >= palette_limit_i) begin
            phase_d = PhIdle;
            res_o.status = StPalette;
          end else begin
            res_o.send_word = {8'h63, palette_i};
          end
        end
        PhHandshake: begin
          phase_d = PhIdle;
          if (!all_high) begin
            res_o.status = StWrong;
          end else begin
            res_o.status         = StSuccess;
            res_o.found_clients  = mask_q;
            res_o.handshake_byte = hs_q;
            res_o.answer_slave1  = ans_q[0];
            res_o.answer_slave2  = ans_q[1];
            res_o.answer_slave3  = ans_q[2];
          end
        end
        PhIdle: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      sync_cnt_q <= '0;
      sends_q    <= '0;
      mask_q     <= '0;
      hdr_q      <= '0;
      pend_q     <= '0;
      pal_cnt_q  <= '0;
      for (int i = 0; i < MaxSlaves; i++) ans_q[i] <= 8'hFF;
      hs_q       <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      sync_cnt_q <= sync_cnt_d;
      sends_q    <= sends_d;
      mask_q     <= mask_d;
      hdr_q      <= hdr_d;
      pend_q     <= pend_d;
      pal_cnt_q  <= pal_cnt_d;
      ans_q      <= ans_d;
      hs_q       <= hs_d;
    end
  end

  // Slaves still owing a palette answer are always a subset of the clients.
  `SBM_NEVER(a_pend_in_mask, clk_i, rst_ni, (pend_q & ~mask_q) != 4'd0,
             "pending mask holds a slave that is not a client")
  // The header counter never runs past the header length.
  `SBM_NEVER(a_hdr_range, clk_i, rst_ni, hdr_q > HeaderHalves,
             "header counter out of range")

endmodule

[sv/serial_boot_master_handshake.sv]
`timescale 1ns / 1ps
// Serial boot handshake, master side.
// The input channel (in_valid_i / in_ready_o / in_item_i) carries one item per
// serial exchange: opcode 0 starts the handshake, opcode 1 hands over the slave
// responses of the exchange just finished and the next header halfword.
// Every accepted transfer yields exactly one transfer on the output channel
// (out_valid_o / out_ready_i / out_item_o): the next word to send and whether
// to wait a frame first while the status is busy, or a final status.
// A result is offered on the cycle after its item is accepted, unless the output
// register holds a result not being taken; then it waits in the skid entry. An item can be
// accepted in every cycle while in_ready_o is high, so the rate is one item per cycle when the
// receiver does not stall, with the phase controller fed by three slave lanes side by side.
// A two-entry output buffer lets one item be accepted while an earlier result
// still waits; only when both entries are full does in_ready_o fall, and it
// rises again in the cycle after the receiver takes a result.
// Reset leaves the block idle with the configuration registers at their
// defaults (normal mode, palette 0x81, both attempt limits 128). The
// configuration port writes one register per cycle with cfg_we_i high.
module serial_boot_master_handshake
  import sbm_pkg::*;
#(
  parameter int NUM_SLAVES = NumSlavesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  // Configuration registers.
  logic       normal_q;
  logic [7:0] palette_q;
  logic [7:0] sync_limit_q;
  logic [7:0] pal_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q     <= NormalModeRst;
      palette_q    <= PaletteRst;
      sync_limit_q <= SyncLimitRst;
      pal_limit_q  <= PaletteLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgNormalMode:   normal_q     <= cfg_data_i[0];
        CfgPalette:      palette_q    <= cfg_data_i;
        CfgSyncLimit:    sync_limit_q <= cfg_data_i;
        CfgPaletteLimit: pal_limit_q  <= cfg_data_i;
      endcase
    end
  end

  logic in_fire;
  logic out_fire;

  // Output buffer: the output register and a skid entry behind it.
  logic      out_v_q;
  logic      skid_v_q;
  out_item_t out_q;
  out_item_t skid_q;
  out_item_t res;

  assign in_ready_o  = !skid_v_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;
  assign out_fire    = out_v_q && out_ready_i;

  // Slave lanes. Slaves beyond the parameter, and slaves two and three in
  // normal mode, are seen as answering zero.
  logic [15:0] resp_raw [MaxSlaves];
  logic [15:0] resp     [MaxSlaves];
  lane_res_t   lane_res [MaxSlaves];
  lane_ctl_t   lane_ctl;

  assign resp_raw[0] = in_item_i.resp_slave1;
  assign resp_raw[1] = in_item_i.resp_slave2;
  assign resp_raw[2] = in_item_i.resp_slave3;

  for (genvar g = 0; g < MaxSlaves; g++) begin : g_lane
    assign resp[g] = ((g >= NUM_SLAVES) || (normal_q && (g > 0))) ? 16'h0000 : resp_raw[g];

    sbm_lane #(.LANE(g)) u_lane (
      .resp_i (resp[g]),
      .ctl_i  (lane_ctl),
      .res_o  (lane_res[g])
    );
  end

  // Phase controller, which merges the lane findings into the next result.
  sbm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .opcode_i        (in_item_i.opcode),
    .header_half_i   (in_item_i.header_half),
    .palette_i       (palette_q),
    .sync_limit_i    (sync_limit_q),
    .palette_limit_i (pal_limit_q),
    .lane_i          (lane_res),
    .ctl_o           (lane_ctl),
    .res_o           (res)
  );

  logic out_load;
  assign out_load = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  `SBM_NEVER(a_skid_order, clk_i, rst_ni, skid_v_q && !out_v_q,
             "skid entry holds a result while the output register is empty")
  // After every accepted item, a result is offered in the next cycle.
  `SBM_ASSERT(a_accept_result, clk_i, rst_ni, in_fire |=> out_v_q,
              "accepted transfer produced no result")

endmodule
